// ----- src/sact_pkg.sv -----
// Shared types and constants for the set-associative cache tag model.
package sact_pkg;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned RANK_W = 4;
	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

	typedef enum logic [2:0] {
		REG_LRU_MODE = 3'd0,
		REG_WAYS = 3'd1,
		REG_INDEX_BITS = 3'd2,
		REG_OFFSET_BITS = 3'd3,
		REG_PF_COUNT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic lru_mode;
		logic [3:0] ways_in_use;
		logic [2:0] index_bits;
		logic [4:0] offset_bits;
		logic [3:0] prefetch_count;
	} cfg_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
		sat_inc = (en && v != {CNT_W{1'b1}}) ? v + 1'b1 : v;
	endfunction
endpackage

// ----- src/sact_front.sv -----
// Front end: accepts accesses and queues them for the lookup engine.
module sact_front import sact_pkg::*; #(
	parameter int unsigned ADDR_BITS = 48,
	parameter int unsigned DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic in_cmd,
	input logic [ADDR_BITS-1:0] in_addr,
	output logic q_valid,
	input logic q_pop,
	output logic q_cmd,
	output logic [ADDR_BITS-1:0] q_addr
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	logic [ADDR_BITS:0] mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;
	logic push;

	assign in_ready = (cnt_q != (PW+1)'(DEPTH));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != '0);
	assign {q_cmd, q_addr} = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= {in_cmd, in_addr};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (q_pop) rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(q_pop);
		end
	end
endmodule

// ----- src/sact_store.sv -----
// One tag store: set-serial lookup and fill with FIFO/LRU way ranks.
module sact_store import sact_pkg::*; #(
	parameter int unsigned NUM_SETS = 64,
	parameter int unsigned NUM_WAYS = 8,
	parameter int unsigned ADDR_BITS = 48
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic start,
	input logic [ADDR_BITS-1:0] blk,
	output logic idle,
	output logic done,
	output logic hit
);
	localparam int unsigned SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int unsigned WW = $clog2(NUM_WAYS + 1);
	localparam int unsigned WI = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_UPD = 4'b0100,
		S_CLR = 4'b1000
	} st_t;

	st_t st_q;
	logic [SW-1:0] clr_q;
	logic [NUM_WAYS-1:0][ADDR_BITS-1:0] tag_mem [NUM_SETS];
	logic [NUM_WAYS-1:0] vld_mem [NUM_SETS];
	logic [NUM_WAYS-1:0][RANK_W-1:0] rank_mem [NUM_SETS];
	logic [NUM_WAYS-1:0][ADDR_BITS-1:0] rtag_s1;
	logic [NUM_WAYS-1:0] rvld_s1;
	logic [NUM_WAYS-1:0][RANK_W-1:0] rrank_s1;
	logic [NUM_WAYS-1:0] vld_nx;
	logic [NUM_WAYS-1:0][RANK_W-1:0] rank_nx;
	logic [SW-1:0] set_q;
	logic [ADDR_BITS-1:0] blk_q;
	logic [SW-1:0] set_d;
	logic [ADDR_BITS-1:0] imask;
	logic [WW-1:0] ways;
	logic [NUM_WAYS-1:0] hv, fv;
	logic [WI-1:0] hi, fi;
	logic any_h, any_f;

	always_comb begin
		imask = ~({ADDR_BITS{1'b1}} << cfg.index_bits);
		set_d = SW'(64'(blk & imask) % NUM_SETS);
		if (cfg.ways_in_use == 4'd0) ways = WW'(1);
		else if (32'(cfg.ways_in_use) > NUM_WAYS) ways = WW'(NUM_WAYS);
		else ways = WW'(cfg.ways_in_use);
		for (int i = 0; i < NUM_WAYS; i++) begin
			hv[i] = (i < 32'(ways)) && rvld_s1[i] && rtag_s1[i] == blk_q;
			fv[i] = (i < 32'(ways)) && (32'(rrank_s1[i]) == 32'(ways) || !rvld_s1[i]);
		end
		any_h = |hv;
		any_f = |fv;
		hi = '0;
		fi = '0;
		for (int i = NUM_WAYS - 1; i >= 0; i--) begin
			if (hv[i]) hi = WI'(i);
			if (fv[i]) fi = WI'(i);
		end
		vld_nx = rvld_s1;
		rank_nx = rrank_s1;
		if (any_h) begin
			if (cfg.lru_mode) begin
				for (int j = 0; j < NUM_WAYS; j++)
					if (j < 32'(ways) && j != 32'(hi) && rvld_s1[j] &&
						rrank_s1[j] < rrank_s1[hi] && rrank_s1[j] < RANK_MAX)
						rank_nx[j] = rrank_s1[j] + 1'b1;
				rank_nx[hi] = RANK_W'(1);
			end
		end else if (any_f) begin
			vld_nx[fi] = 1'b1;
			for (int j = 0; j < NUM_WAYS; j++)
				if (j < 32'(ways) && j != 32'(fi) && rrank_s1[j] < RANK_MAX)
					rank_nx[j] = rrank_s1[j] + 1'b1;
			rank_nx[fi] = RANK_W'(1);
		end
	end

	assign idle = (st_q == S_IDLE);
	assign done = (st_q == S_UPD);
	assign hit = any_h;

	always_ff @(posedge clk) begin
		if (st_q == S_READ) begin
			rtag_s1 <= tag_mem[set_q];
			rvld_s1 <= vld_mem[set_q];
			rrank_s1 <= rank_mem[set_q];
		end
		if (st_q == S_IDLE && start) begin
			blk_q <= blk;
			set_q <= set_d;
		end
		if (st_q == S_UPD && !any_h && any_f) tag_mem[set_q][fi] <= blk_q;
		if (st_q == S_CLR) begin
			vld_mem[clr_q] <= '0;
			rank_mem[clr_q] <= '0;
		end else if (st_q == S_UPD) begin
			vld_mem[set_q] <= vld_nx;
			rank_mem[set_q] <= rank_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			clr_q <= '0;
		end else begin
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(NUM_SETS - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (start) st_q <= S_READ;
				S_READ: st_q <= S_UPD;
				S_UPD: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- src/sact_back.sv -----
// Back end: runs both tag stores, prefetch sequence, counters and output register.
module sact_back import sact_pkg::*; #(
	parameter int unsigned NUM_SETS = 64,
	parameter int unsigned NUM_WAYS = 8,
	parameter int unsigned ADDR_BITS = 48,
	parameter int unsigned MAX_PREFETCH = 15
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic q_valid,
	output logic q_pop,
	input logic q_cmd,
	input logic [ADDR_BITS-1:0] q_addr,
	output logic out_valid,
	input logic out_ready,
	output logic [2+8*CNT_W-1:0] out_data
);
	localparam int unsigned PFW = $clog2(MAX_PREFETCH + 1);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_MAIN = 5'b00010,
		B_PF = 5'b00100,
		B_PFW = 5'b01000,
		B_OUT = 5'b10000
	} bst_t;

	bst_t st_q;
	logic cmd_q, ph_q, fh_q;
	logic [ADDR_BITS-1:0] pa_q;
	logic [PFW-1:0] n_q;
	logic [CNT_W-1:0] cnt_q [8];
	logic p_start, f_start, p_done, f_done, p_hit, f_hit, p_idle, f_idle;
	logic [ADDR_BITS-1:0] f_blk, pa_nx, step;
	logic [PFW-1:0] n_cfg;

	assign step = ADDR_BITS'(1) << cfg.offset_bits;
	assign pa_nx = pa_q + step;
	assign n_cfg = (32'(cfg.prefetch_count) > MAX_PREFETCH) ? PFW'(MAX_PREFETCH)
		: PFW'(cfg.prefetch_count);
	assign p_start = (st_q == B_IDLE) && q_valid && p_idle && f_idle;
	assign f_start = p_start || (st_q == B_PF);
	assign f_blk = (st_q == B_IDLE) ? (q_addr >> cfg.offset_bits) : (pa_nx >> cfg.offset_bits);
	assign q_pop = p_start;
	assign out_valid = (st_q == B_OUT);
	assign out_data = {cnt_q[7], cnt_q[6], cnt_q[5], cnt_q[4], cnt_q[3], cnt_q[2],
		cnt_q[1], cnt_q[0], fh_q, ph_q};

	sact_store #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .ADDR_BITS(ADDR_BITS)) u_plain (
		.clk, .arst_n, .cfg, .start(p_start), .blk(q_addr >> cfg.offset_bits),
		.idle(p_idle), .done(p_done), .hit(p_hit));
	sact_store #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .ADDR_BITS(ADDR_BITS)) u_pf (
		.clk, .arst_n, .cfg, .start(f_start), .blk(f_blk), .idle(f_idle), .done(f_done),
		.hit(f_hit));

	always_ff @(posedge clk) begin
		if (p_start) begin
			cmd_q <= q_cmd;
			pa_q <= q_addr;
		end
		if (st_q == B_MAIN && p_done) begin
			ph_q <= p_hit;
			fh_q <= f_hit;
		end
		if (st_q == B_PF) pa_q <= pa_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			n_q <= '0;
			for (int k = 0; k < 8; k++) cnt_q[k] <= '0;
		end else begin
			unique case (st_q)
				B_IDLE: if (p_start) st_q <= B_MAIN;
				B_MAIN: if (p_done) begin
					cnt_q[2] <= sat_inc(cnt_q[2], p_hit);
					cnt_q[3] <= sat_inc(cnt_q[3], !p_hit);
					cnt_q[0] <= sat_inc(cnt_q[0], !p_hit);
					cnt_q[1] <= sat_inc(cnt_q[1], cmd_q);
					cnt_q[6] <= sat_inc(cnt_q[6], f_hit);
					cnt_q[7] <= sat_inc(cnt_q[7], !f_hit);
					cnt_q[4] <= sat_inc(cnt_q[4], !f_hit);
					cnt_q[5] <= sat_inc(cnt_q[5], cmd_q);
					n_q <= n_cfg;
					st_q <= (!f_hit && n_cfg != '0) ? B_PF : B_OUT;
				end
				B_PF: begin
					n_q <= n_q - 1'b1;
					st_q <= B_PFW;
				end
				B_PFW: if (f_done) begin
					cnt_q[4] <= sat_inc(cnt_q[4], !f_hit);
					st_q <= (n_q == '0) ? B_OUT : B_PF;
				end
				B_OUT: if (out_ready) st_q <= B_IDLE;
				default: st_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ----- src/set_assoc_cache_tag_model_core.sv -----
// Top level: cache tag model with APB configuration and stream ports.
// Each access reads and updates both tag stores; on a prefetch-store miss it then runs
// prefetch_count further lookups (at most 15) in the prefetch store, one after another.
// The next access starts only after the result beat is taken; later ones wait in the queue.
// Reset: counters clear at once, registers take defaults; valid bits and ranks clear
// in a pass over the NUM_SETS sets (64 by default), while accesses wait in the input queue.
module set_assoc_cache_tag_model_core import sact_pkg::*; #(
	parameter int unsigned NUM_SETS = 64,
	parameter int unsigned NUM_WAYS = 8,
	parameter int unsigned ADDR_BITS = 48,
	parameter int unsigned MAX_PREFETCH = 15
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [55:0] s_axis_tdata, // cmd, address[47:0], zero pad
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [263:0] m_axis_tdata, // plain_hit, prefetch_hit, 8 counters, pad
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	cfg_t cfg_q;
	logic q_valid, q_pop, q_cmd;
	logic [ADDR_BITS-1:0] q_addr, in_addr;
	logic [2+8*CNT_W-1:0] res;
	reg_idx_t ridx;

	assign pready = 1'b1;
	assign ridx = reg_idx_t'(paddr[4:2]);
	assign in_addr = (ADDR_BITS >= 48) ? ADDR_BITS'(s_axis_tdata[48:1])
		: ADDR_BITS'(s_axis_tdata[48:1]);

	always_comb begin
		prdata = '0;
		unique case (ridx)
			REG_LRU_MODE: prdata = 32'(cfg_q.lru_mode);
			REG_WAYS: prdata = 32'(cfg_q.ways_in_use);
			REG_INDEX_BITS: prdata = 32'(cfg_q.index_bits);
			REG_OFFSET_BITS: prdata = 32'(cfg_q.offset_bits);
			REG_PF_COUNT: prdata = 32'(cfg_q.prefetch_count);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{lru_mode: 1'b0, ways_in_use: 4'd1, index_bits: 3'd0,
				offset_bits: 5'd4, prefetch_count: 4'd0};
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			unique case (ridx)
				REG_LRU_MODE: cfg_q.lru_mode <= pwdata[0];
				REG_WAYS: cfg_q.ways_in_use <= pwdata[3:0];
				REG_INDEX_BITS: cfg_q.index_bits <= pwdata[2:0];
				REG_OFFSET_BITS: cfg_q.offset_bits <= pwdata[4:0];
				REG_PF_COUNT: cfg_q.prefetch_count <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	sact_front #(.ADDR_BITS(ADDR_BITS), .DEPTH(2)) u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd(s_axis_tdata[0]), .in_addr, .q_valid, .q_pop, .q_cmd, .q_addr);

	sact_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .ADDR_BITS(ADDR_BITS),
		.MAX_PREFETCH(MAX_PREFETCH)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_valid, .q_pop, .q_cmd, .q_addr,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res));

	assign m_axis_tdata = {6'd0, res};
endmodule

// ----- test/set_assoc_cache_tag_model_checker.sv -----
// Checker: predicts plain and prefetch tag-store behavior and compares result beats.
`timescale 1ns / 1ps
module set_assoc_cache_tag_model_checker import sact_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [55:0] s_axis_tdata, // cmd, address[47:0], zero pad
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [263:0] m_axis_tdata, // plain_hit, prefetch_hit, 8 counters, pad
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	input logic pready,
	output int errors,
	output int pending,
	output int results
);
	localparam int SETS = 64;
	localparam int WAYS = 8;
	localparam logic [47:0] AMASK = {48{1'b1}};

	typedef struct packed {
		logic [7:0][31:0] cnt;
		logic pf_hit;
		logic pl_hit;
	} access_result_t;

	cfg_t cfg;
	logic [47:0] tag_q [2][SETS*WAYS];
	logic valid_q [2][SETS*WAYS];
	logic [3:0] rank_q [2][SETS*WAYS];
	logic [31:0] evt_cnt [8];
	access_result_t expected_q [$];

	assign pending = expected_q.size();

	function automatic int eff_ways();
		if (cfg.ways_in_use == 0) return 1;
		if (cfg.ways_in_use > WAYS) return WAYS;
		return cfg.ways_in_use;
	endfunction

	function automatic void bump_evt(int k);
		if (evt_cnt[k] != 32'hFFFFFFFF) evt_cnt[k]++;
	endfunction

	function automatic void age(int st, int e);
		if (rank_q[st][e] != RANK_MAX) rank_q[st][e]++;
	endfunction

	// lookup with fill on miss; returns hit
	function automatic bit tag_lookup(int st, logic [47:0] blk);
		int ways;
		int base;
		logic [3:0] old;
		ways = eff_ways();
		base = int'(blk & ((64'd1 << cfg.index_bits) - 1) & 63) * WAYS;
		for (int i = 0; i < ways; i++) begin
			if (valid_q[st][base+i] && tag_q[st][base+i] == blk) begin
				if (cfg.lru_mode) begin
					old = rank_q[st][base+i];
					for (int j = 0; j < ways; j++)
						if (j != i && valid_q[st][base+j] && rank_q[st][base+j] < old)
							age(st, base + j);
					rank_q[st][base+i] = 1;
				end
				return 1;
			end
		end
		for (int i = 0; i < ways; i++) begin
			if (rank_q[st][base+i] == ways || !valid_q[st][base+i]) begin
				tag_q[st][base+i] = blk;
				valid_q[st][base+i] = 1;
				rank_q[st][base+i] = 1;
				for (int j = 0; j < ways; j++)
					if (j != i) age(st, base + j);
				break;
			end
		end
		return 0;
	endfunction

	function automatic void tally(int first, bit hit, logic cmd);
		if (hit) begin
			bump_evt(first + 2);
		end else begin
			bump_evt(first + 3);
			bump_evt(first);
		end
		if (cmd) bump_evt(first + 1);
	endfunction

	function automatic access_result_t predict_access(logic cmd, logic [47:0] addr);
		access_result_t r;
		logic [63:0] pa;
		logic [47:0] blk;
		bit ph;
		bit fh;
		blk = addr >> cfg.offset_bits;
		ph = tag_lookup(0, blk);
		tally(0, ph, cmd);
		fh = tag_lookup(1, blk);
		tally(4, fh, cmd);
		if (!fh) begin
			pa = addr;
			for (int k = 0; k < cfg.prefetch_count; k++) begin
				pa = (pa + (64'd1 << cfg.offset_bits)) & AMASK;
				if (!tag_lookup(1, 48'(pa >> cfg.offset_bits))) bump_evt(4);
			end
		end
		r.pl_hit = ph;
		r.pf_hit = fh;
		for (int k = 0; k < 8; k++) r.cnt[k] = evt_cnt[k];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		access_result_t exp_r;
		access_result_t got_r;
		if (!arst_n) begin
			for (int s = 0; s < 2; s++)
				for (int e = 0; e < SETS*WAYS; e++) begin
					valid_q[s][e] = 0;
					rank_q[s][e] = 0;
				end
			for (int k = 0; k < 8; k++) evt_cnt[k] = 0;
			cfg = '{lru_mode: 1'b0, ways_in_use: 4'd1, index_bits: 3'd0,
				offset_bits: 5'd4, prefetch_count: 4'd0};
			expected_q.delete();
			errors = 0;
			results = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr >> 2)
					REG_LRU_MODE: cfg.lru_mode = pwdata[0];
					REG_WAYS: cfg.ways_in_use = pwdata[3:0];
					REG_INDEX_BITS: cfg.index_bits = pwdata[2:0];
					REG_OFFSET_BITS: cfg.offset_bits = pwdata[4:0];
					REG_PF_COUNT: cfg.prefetch_count = pwdata[3:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(predict_access(s_axis_tdata[0], s_axis_tdata[48:1]));
			if (m_axis_tvalid && m_axis_tready) begin
				got_r = m_axis_tdata[257:0];
				results++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat %h", $realtime, got_r);
				end else begin
					exp_r = expected_q.pop_front();
					if (got_r.pl_hit !== exp_r.pl_hit) begin
						errors++;
						$display("%0t: plain_hit exp %b got %b", $realtime,
							exp_r.pl_hit, got_r.pl_hit);
					end
					if (got_r.pf_hit !== exp_r.pf_hit) begin
						errors++;
						$display("%0t: prefetch_hit exp %b got %b", $realtime,
							exp_r.pf_hit, got_r.pf_hit);
					end
					for (int k = 0; k < 8; k++)
						if (got_r.cnt[k] !== exp_r.cnt[k]) begin
							errors++;
							$display("%0t: counter %0d exp %0d got %0d", $realtime, k,
								exp_r.cnt[k], got_r.cnt[k]);
						end
				end
			end
		end
	end
endmodule

// ----- test/tb.sv -----
// Testbench top: clock, reset, stimulus and verdict for the cache tag model.
`timescale 1ns / 1ps
module tb;
	import sact_pkg::*;

	localparam int LIMIT = 1500000;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [55:0] s_axis_tdata; // cmd, address[47:0], zero pad
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [263:0] m_axis_tdata; // plain_hit, prefetch_hit, 8 counters, pad
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int errors;
	int pending;
	int results;

	int cyc;
	int idle_mode;
	int hold_until;
	int sent;
	int phases;
	logic [3:0] cur_ways;
	logic [2:0] cur_idx;
	logic [4:0] cur_off;
	logic [47:0] bases [4];

	set_assoc_cache_tag_model_core i_dut (.*);

	set_assoc_cache_tag_model_checker i_chk (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (cyc < hold_until)
				m_axis_tready <= 1'b0;
			else if (idle_mode == 2)
				m_axis_tready <= $urandom_range(99) >= 82;
			else if (idle_mode == 3)
				m_axis_tready <= $urandom_range(99) >= 17;
			else
				m_axis_tready <= 1'b1;
		end
	end

	task automatic access(logic cmd, logic [47:0] addr);
		while ((idle_mode == 1 && $urandom_range(99) < 82) ||
			(idle_mode == 3 && $urandom_range(99) < 17)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, addr, cmd};
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 5'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_cfg(logic lru, logic [3:0] ways, logic [2:0] idx, logic [4:0] off,
		logic [3:0] pfc);
		reg_write(REG_LRU_MODE, {31'd0, lru});
		reg_write(REG_WAYS, {28'd0, ways});
		reg_write(REG_INDEX_BITS, {29'd0, idx});
		reg_write(REG_OFFSET_BITS, {27'd0, off});
		reg_write(REG_PF_COUNT, {28'd0, pfc});
		cur_ways = ways;
		cur_idx = idx;
		cur_off = off;
		for (int i = 0; i < 4; i++) bases[i] = 48'({$urandom, $urandom});
		phases++;
	endtask

	function automatic logic [47:0] rand_addr();
		int k;
		logic [63:0] span;
		if ($urandom_range(99) < 25) return 48'({$urandom, $urandom});
		k = cur_off + (cur_idx > 6 ? 6 : cur_idx) + 2 + $urandom_range(2);
		if (k > 44) k = 44;
		span = {$urandom, $urandom} & ((64'd1 << k) - 1);
		return 48'(bases[$urandom_range(3)] + span);
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) access(1'($urandom_range(1)), rand_addr());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cyc = 0;
		idle_mode = 0;
		hold_until = 0;
		sent = 0;
		phases = 0;
		cur_ways = 4'd1;
		cur_idx = 3'd0;
		cur_off = 5'd4;
		for (int i = 0; i < 4; i++) bases[i] = 48'({$urandom, $urandom});
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: miss, hit, eviction, bit patterns
		access(1'b0, 48'h0);
		access(1'b1, 48'h0);
		access(1'b1, 48'hFFFF_FFFF_FFFF);
		access(1'b0, 48'hFFFF_FFFF_FFF0);
		access(1'b0, 48'h10);
		access(1'b1, 48'h0);
		access(1'b0, 48'hAAAA_AAAA_AAAA);
		access(1'b1, 48'h5555_5555_5555);
		drain();
		// max prefetch with address wrap, LRU prefetch hits
		set_cfg(1'b1, 4'd8, 3'd6, 5'd4, 4'd15);
		access(1'b0, 48'hFFFF_FFFF_FF80);
		access(1'b0, 48'h0000_0000_0040);
		access(1'b1, 48'hFFFF_FFFF_FFF0);
		access(1'b0, 48'h0);
		access(1'b0, 48'h1000);
		drain();
		// shrink ways with live state: victim may be missing
		reg_write(REG_WAYS, 32'd2);
		access(1'b0, 48'h2000);
		access(1'b1, 48'h3000);
		drain();
		// out of range ways, oversized index, extreme offsets, unknown register
		set_cfg(1'b0, 4'd0, 3'd7, 5'd31, 4'd3);
		reg_write(reg_idx_t'(3'd7), 32'hFFFF_FFFF);
		access(1'b0, 48'h8000_0000_0000);
		access(1'b1, 48'h7FFF_FFFF_FFFF);
		drain();
		set_cfg(1'b1, 4'd15, 3'd0, 5'd0, 4'd1);
		access(1'b0, 48'h1);
		access(1'b0, 48'h2);
		access(1'b1, 48'h1);
		drain();

		// receiver holds off while the sender keeps offering beats
		set_cfg(1'b1, 4'd4, 3'd2, 5'd6, 4'd3);
		hold_until = cyc + 400;
		run_random(40);

		for (int p = 0; p < 16; p++) begin
			idle_mode = p % 4;
			case (p)
				0: set_cfg(1'b0, 4'd8, 3'd6, 5'd16, 4'd15);
				1: set_cfg(1'b1, 4'd8, 3'd0, 5'd0, 4'd0);
				2: set_cfg(1'b0, 4'd1, 3'd6, 5'd4, 4'd15);
				3: set_cfg(1'b1, 4'd2, 3'd3, 5'd5, 4'd2);
				default: set_cfg(1'($urandom_range(1)), 4'($urandom_range(15)),
					3'($urandom_range(7)), 5'($urandom_range(31)), 4'($urandom_range(15)));
			endcase
			run_random(40);
		end
		idle_mode = 0;

		$display("Ran %0d accesses over %0d settings; %0d result beats checked.",
			sent, phases, results);
		$display("Covered FIFO/LRU, 0..15 ways, index/offset extremes, prefetch 0..15.");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ----- set_assoc_cache_tag_model_core.f -----
src/sact_pkg.sv
src/sact_front.sv
src/sact_store.sv
src/sact_back.sv
src/set_assoc_cache_tag_model_core.sv
test/set_assoc_cache_tag_model_checker.sv
test/tb.sv
